@@ src/tcw_pkg.sv @@
// Shared types and constants for the text console writer.
package tcw_pkg;

	localparam int unsigned COLUMNS_DEF = 80;
	localparam int unsigned ROWS_DEF = 25;

	localparam logic [7:0] TEXT_COLOR_RST = 8'd143;
	localparam logic [7:0] NEWLINE_CODE = 8'd10;
	localparam logic [7:0] SPACE_CODE = 8'd32;

	typedef enum logic [1:0] {
		CMD_PUT = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_READ = 2'd2
	} cmd_t;

	typedef struct packed {
		logic [6:0] cursor_col;
		logic [4:0] cursor_row;
		logic [7:0] cell_attr;
		logic [7:0] cell_char;
	} res_t;

endpackage

@@ src/text_console_writer.sv @@
// Top level: color register, sequencer, screen store and output register.
// Put: cell write, then result; in-range read: read wait, then result; other requests and a
// newline without scroll: straight to result. Scroll: each cell of rows 1..ROWS-1 is read and
// written one row up, the last row is blanked, then a wrapping put is written. Clear blanks
// every cell. One request at a time; every cell move goes through the single memory port.
// Reset clears cursor to 0,0 and color to 143; screen content is undefined until written.
module text_console_writer #(
	parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int unsigned ROWS = tcw_pkg::ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // char_code[7:0], read_row[12:8], read_col[19:13]
	input  logic [1:0]  s_tuser,  // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // cell_char[7:0], cell_attr[15:8], cursor_row_out[20:16],
	                              // cursor_col_out[27:21]
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);

	localparam int unsigned DEPTH = ROWS * COLUMNS;
	localparam int unsigned ADDR_W = $clog2(DEPTH);

	logic              res_valid;
	logic              res_ready;
	tcw_pkg::res_t     res;
	logic [7:0]        text_color_q;
	logic              m_valid_q;
	tcw_pkg::res_t     m_res_q;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_addr;
	logic [15:0]       mem_wdata;
	logic [15:0]       mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= tcw_pkg::TEXT_COLOR_RST;
		end else if (cfg_we) begin
			text_color_q <= cfg_wdata;
		end
	end

	tcw_ctrl #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS),
		.ADDR_W(ADDR_W)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.text_color(text_color_q),
		.req_valid(s_tvalid),
		.req_ready(s_tready),
		.req_cmd(tcw_pkg::cmd_t'(s_tuser)),
		.req_char(s_tdata[7:0]),
		.req_row(s_tdata[12:8]),
		.req_col(s_tdata[19:13]),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.mem_we(mem_we),
		.mem_addr(mem_addr),
		.mem_wdata(mem_wdata),
		.mem_rdata(mem_rdata)
	);

	tcw_mem #(
		.DEPTH(DEPTH),
		.ADDR_W(ADDR_W)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.addr(mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	assign res_ready = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = {4'd0, m_res_q};

`ifndef NO_ASSERTIONS
	a_no_accept_while_resp: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !res_valid) else $error("request taken while result pending");
	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !res_ready) else $error("output overwritten while stalled");
	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready) |=> m_tvalid) else $error("result lost");
`endif

endmodule

@@ src/tcw_mem.sv @@
// Single-port screen store, one registered read per cycle while not writing; rdata holds during a write.
module tcw_mem #(
	parameter int unsigned DEPTH = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF,
	parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] addr,
	input  logic [15:0]       wdata,
	output logic [15:0]       rdata
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rdata <= mem[addr];
		end
	end

endmodule

@@ src/tcw_ctrl.sv @@
// Command sequencer: cursor, scroll and clear walks, cell writes and reads.
module tcw_ctrl #(
	parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int unsigned ROWS = tcw_pkg::ROWS_DEF,
	parameter int unsigned ADDR_W = $clog2(ROWS * COLUMNS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        text_color,
	input  logic              req_valid,
	output logic              req_ready,
	input  tcw_pkg::cmd_t     req_cmd,
	input  logic [7:0]        req_char,
	input  logic [4:0]        req_row,
	input  logic [6:0]        req_col,
	output logic              res_valid,
	input  logic              res_ready,
	output tcw_pkg::res_t     res,
	output logic              mem_we,
	output logic [ADDR_W-1:0] mem_addr,
	output logic [15:0]       mem_wdata,
	input  logic [15:0]       mem_rdata
);

	localparam int unsigned ROW_W = $clog2(ROWS);
	localparam int unsigned COL_W = $clog2(COLUMNS + 1);
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
	localparam logic [COL_W-1:0] COL_FULL = COL_W'(COLUMNS);
	localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);
	localparam logic [ADDR_W-1:0] SCROLL_LAST = ADDR_W'((ROWS - 1) * COLUMNS - 1);
	localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(ROWS * COLUMNS - 1);

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_SCR_RD  = 7'b0000010,
		ST_SCR_WR  = 7'b0000100,
		ST_BLANK   = 7'b0001000,
		ST_WRITE   = 7'b0010000,
		ST_RD_WAIT = 7'b0100000,
		ST_RESP    = 7'b1000000
	} state_t;

	state_t            state_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic              pend_q;
	logic [ADDR_W-1:0] ptr_q;
	logic [7:0]        char_q;
	logic [15:0]       cell_q;
	logic              in_range;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;

	assign in_range = (32'(req_row) < 32'(ROWS)) && (32'(req_col) < 32'(COLUMNS));
	assign rd_addr = ADDR_W'(req_row) * ROW_STRIDE + ADDR_W'(req_col);
	assign wr_addr = ADDR_W'(row_q) * ROW_STRIDE + ADDR_W'(col_q);

	assign req_ready = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_RESP);
	assign res = '{cursor_col: 7'(col_q), cursor_row: 5'(row_q),
		cell_attr: cell_q[15:8], cell_char: cell_q[7:0]};

	always_comb begin
		mem_we = 1'b0;
		mem_addr = ptr_q;
		mem_wdata = {text_color, tcw_pkg::SPACE_CODE};
		unique case (state_q)
			ST_IDLE: begin
				mem_addr = rd_addr;
			end
			ST_SCR_RD: begin
				mem_addr = ptr_q + ROW_STRIDE;
			end
			ST_SCR_WR: begin
				mem_we = 1'b1;
				mem_wdata = mem_rdata;
			end
			ST_BLANK: begin
				mem_we = 1'b1;
			end
			ST_WRITE: begin
				mem_we = 1'b1;
				mem_addr = wr_addr;
				mem_wdata = {text_color, char_q};
			end
			default: begin
				mem_addr = ptr_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q <= '0;
			col_q <= '0;
			pend_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						// only looked at when a blank walk ends, after a scroll or a clear
						pend_q <= (req_cmd == tcw_pkg::CMD_PUT) &&
							(req_char != tcw_pkg::NEWLINE_CODE);
						case (req_cmd)
							tcw_pkg::CMD_PUT: begin
								if (req_char == tcw_pkg::NEWLINE_CODE || col_q == COL_FULL) begin
									col_q <= '0;
									if (row_q != LAST_ROW) begin
										row_q <= row_q + ROW_W'(1);
										state_q <= (req_char == tcw_pkg::NEWLINE_CODE) ?
											ST_RESP : ST_WRITE;
									end else begin
										state_q <= ST_SCR_RD;
									end
								end else begin
									state_q <= ST_WRITE;
								end
							end
							tcw_pkg::CMD_CLEAR: state_q <= ST_BLANK;
							tcw_pkg::CMD_READ:  state_q <= in_range ? ST_RD_WAIT : ST_RESP;
							default:            state_q <= ST_RESP;
						endcase
					end
				end
				ST_SCR_RD: state_q <= ST_SCR_WR;
				ST_SCR_WR: state_q <= (ptr_q == SCROLL_LAST) ? ST_BLANK : ST_SCR_RD;
				ST_BLANK: begin
					if (ptr_q == LAST_CELL) begin
						state_q <= pend_q ? ST_WRITE : ST_RESP;
					end
				end
				ST_WRITE: begin
					col_q <= col_q + COL_W'(1);
					state_q <= ST_RESP;
				end
				ST_RD_WAIT: state_q <= ST_RESP;
				ST_RESP: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ptr_q <= '0;
				char_q <= req_char;
				cell_q <= '0;
			end
			ST_SCR_WR:  ptr_q <= ptr_q + ADDR_W'(1);
			ST_BLANK:   ptr_q <= ptr_q + ADDR_W'(1);
			ST_RD_WAIT: cell_q <= mem_rdata;
			default: begin
				ptr_q <= ptr_q;
			end
		endcase
	end

endmodule

@@ dv/text_console_writer_test.sv @@
// Testbench for text_console_writer: self-checking stream test with a console scoreboard.
`timescale 1ns / 100ps

module text_console_writer_test;

	localparam int unsigned NUM_ROWS = tcw_pkg::ROWS_DEF;
	localparam int unsigned NUM_COLS = tcw_pkg::COLUMNS_DEF;
	localparam int unsigned NUM_CELLS = NUM_ROWS * NUM_COLS;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned DRAIN_CYCLES = 4000;

	class console_scoreboard;
		logic [15:0] cells [NUM_CELLS];
		bit written [NUM_CELLS];
		int unsigned row;
		int unsigned col;
		logic [7:0] color;
		tcw_pkg::res_t expected_q[$];
		int unsigned errors;
		int unsigned requests;
		int unsigned reads;
		int unsigned clears;
		int unsigned scrolls;
		int unsigned wraps;
		int unsigned full_newlines;

		function new();
			row = 0;
			col = 0;
			color = tcw_pkg::TEXT_COLOR_RST;
			foreach (written[i])
				written[i] = 1'b0;
		endfunction

		function void set_color(logic [7:0] v);
			color = v;
		endfunction

		function bit cell_written(logic [4:0] r, logic [6:0] c);
			return written[int'(r) * NUM_COLS + int'(c)];
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		function void blank_row(int unsigned r);
			for (int unsigned c = 0; c < NUM_COLS; c++) begin
				cells[r * NUM_COLS + c] = {color, tcw_pkg::SPACE_CODE};
				written[r * NUM_COLS + c] = 1'b1;
			end
		endfunction

		function void advance_line();
			col = 0;
			if (row < NUM_ROWS - 1) begin
				row++;
			end else begin
				for (int unsigned i = 0; i < (NUM_ROWS - 1) * NUM_COLS; i++) begin
					cells[i] = cells[i + NUM_COLS];
					written[i] = written[i + NUM_COLS];
				end
				blank_row(NUM_ROWS - 1);
				scrolls++;
			end
		endfunction

		function void note_request(logic [1:0] cmd, logic [7:0] ch, logic [4:0] rr,
				logic [6:0] rc);
			tcw_pkg::res_t want;
			want = '0;
			requests++;
			case (cmd)
				tcw_pkg::CMD_PUT: begin
					if (ch == tcw_pkg::NEWLINE_CODE) begin
						if (col >= NUM_COLS)
							full_newlines++;
						advance_line();
					end else begin
						if (col >= NUM_COLS) begin
							advance_line();
							wraps++;
						end
						cells[row * NUM_COLS + col] = {color, ch};
						written[row * NUM_COLS + col] = 1'b1;
						col++;
					end
				end
				tcw_pkg::CMD_CLEAR: begin
					for (int unsigned r = 0; r < NUM_ROWS; r++)
						blank_row(r);
					clears++;
				end
				tcw_pkg::CMD_READ: begin
					if (rr < NUM_ROWS && rc < NUM_COLS) begin
						want.cell_char = cells[int'(rr) * NUM_COLS + int'(rc)][7:0];
						want.cell_attr = cells[int'(rr) * NUM_COLS + int'(rc)][15:8];
						reads++;
					end
				end
				default: ;
			endcase
			want.cursor_row = row[4:0];
			want.cursor_col = col[6:0];
			expected_q.push_back(want);
		endfunction

		function void check_result(logic [31:0] word);
			tcw_pkg::res_t got;
			tcw_pkg::res_t want;
			got = word[27:0];
			if (expected_q.size() == 0) begin
				$error("unexpected result %h with no request outstanding", word);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.cell_char !== want.cell_char) begin
				$error("cell_char expected %0d got %0d", want.cell_char, got.cell_char);
				errors++;
			end
			if (got.cell_attr !== want.cell_attr) begin
				$error("cell_attr expected %0d got %0d", want.cell_attr, got.cell_attr);
				errors++;
			end
			if (got.cursor_row !== want.cursor_row) begin
				$error("cursor_row_out expected %0d got %0d", want.cursor_row, got.cursor_row);
				errors++;
			end
			if (got.cursor_col !== want.cursor_col) begin
				$error("cursor_col_out expected %0d got %0d", want.cursor_col, got.cursor_col);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [23:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [7:0] cfg_wdata = '0;

	logic hold_req = 1'b0;
	int unsigned hold_left = 0;
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	int unsigned color_writes = 0;

	console_scoreboard sb = new();

	text_console_writer uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (hold_req) begin
			hold_req <= 1'b0;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	function automatic logic [7:0] rand_char();
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [4:0] rand_row();
		return 5'($urandom_range(31));
	endfunction

	function automatic logic [6:0] rand_col();
		return 7'($urandom_range(127));
	endfunction

	task automatic send_request(input logic [1:0] cmd, input logic [7:0] ch,
			input logic [4:0] rr, input logic [6:0] rc);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {4'd0, rc, rr, ch};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_request(cmd, ch, rr, rc);
	endtask

	// called right after an accept, so s_tvalid sees one update in this step
	task automatic settle_and_set_color(input logic [7:0] v);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		@(posedge clk);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_color(v);
		color_writes++;
	endtask

	task automatic send_read(input bit full_range);
		logic [4:0] rr;
		logic [6:0] rc;
		rr = full_range ? rand_row() : 5'($urandom_range(NUM_ROWS - 1));
		rc = full_range ? rand_col() : 7'($urandom_range(NUM_COLS - 1));
		// never touch a cell that has not been written yet
		if (rr < NUM_ROWS && rc < NUM_COLS && !sb.cell_written(rr, rc))
			rr = 5'(NUM_ROWS + $urandom_range(31 - NUM_ROWS));
		send_request(tcw_pkg::CMD_READ, rand_char(), rr, rc);
	endtask

	task automatic walk_to_last_row();
		while (sb.row < NUM_ROWS - 1)
			send_request(tcw_pkg::CMD_PUT, tcw_pkg::NEWLINE_CODE, rand_row(), rand_col());
		send_request(tcw_pkg::CMD_PUT, tcw_pkg::NEWLINE_CODE, rand_row(), rand_col());
	endtask

	task automatic fill_line(input bit end_with_newline);
		logic [7:0] ch;
		while (sb.col < NUM_COLS) begin
			ch = rand_char();
			if (ch == tcw_pkg::NEWLINE_CODE)
				ch = tcw_pkg::SPACE_CODE;
			send_request(tcw_pkg::CMD_PUT, ch, rand_row(), rand_col());
		end
		ch = end_with_newline ? tcw_pkg::NEWLINE_CODE : 8'(33 + $urandom_range(90));
		send_request(tcw_pkg::CMD_PUT, ch, rand_row(), rand_col());
		send_read(1'b0);
	endtask

	task automatic random_sequence();
		int unsigned pick;
		int unsigned n;
		pick = $urandom_range(99);
		if (pick < 45) begin
			n = $urandom_range(6, 1);
			repeat (n)
				send_request(tcw_pkg::CMD_PUT, rand_char(), rand_row(), rand_col());
			if ($urandom_range(99) < 35)
				send_request(tcw_pkg::CMD_PUT, tcw_pkg::NEWLINE_CODE, rand_row(), rand_col());
		end else if (pick < 57) begin
			n = $urandom_range(5, 1);
			repeat (n)
				send_request(tcw_pkg::CMD_PUT, tcw_pkg::NEWLINE_CODE, rand_row(), rand_col());
		end else if (pick < 75) begin
			send_read(1'b0);
		end else if (pick < 85) begin
			send_read(1'b1);
		end else if (pick < 90) begin
			send_request(tcw_pkg::CMD_CLEAR, rand_char(), rand_row(), rand_col());
		end else begin
			send_request(CMD_UNUSED, rand_char(), rand_row(), rand_col());
		end
	endtask

	task automatic run_phase(input int unsigned tx_pct, input int unsigned rx_pct,
			input int unsigned budget, input bit with_hold);
		int unsigned start;
		bit held;
		start = sb.requests;
		held = 1'b0;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		settle_and_set_color(rand_char());
		while (sb.requests - start < budget) begin
			random_sequence();
			if (with_hold && !held && sb.requests - start >= 4) begin
				hold_req <= 1'b1;
				held = 1'b1;
			end
		end
	endtask

	initial begin
		#12_000_000;
		$display("timeout with %0d results outstanding", sb.pending());
		$display("text_console_writer verification failed");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		tx_idle_pct = 17;
		rx_idle_pct = 65;

		// directed: out of range, unused command, extremes of color and char
		send_request(tcw_pkg::CMD_READ, 8'h00, 5'd31, 7'd127);
		send_request(CMD_UNUSED, 8'hFF, 5'd31, 7'd127);
		send_request(tcw_pkg::CMD_PUT, 8'h41, 5'd0, 7'd0);
		send_request(tcw_pkg::CMD_READ, 8'h00, 5'd0, 7'd0);
		settle_and_set_color(8'h00);
		send_request(tcw_pkg::CMD_PUT, 8'h00, 5'd31, 7'd127);
		send_request(tcw_pkg::CMD_PUT, 8'hFF, 5'd0, 7'd0);
		send_request(tcw_pkg::CMD_READ, 8'hFF, 5'd0, 7'd1);
		send_request(tcw_pkg::CMD_READ, 8'h00, 5'd0, 7'd2);
		send_request(tcw_pkg::CMD_PUT, tcw_pkg::NEWLINE_CODE, 5'd0, 7'd0);
		send_request(tcw_pkg::CMD_PUT, tcw_pkg::SPACE_CODE, 5'd0, 7'd0);
		send_request(tcw_pkg::CMD_READ, 8'h00, 5'd1, 7'd0);
		settle_and_set_color(8'hFF);
		send_request(tcw_pkg::CMD_CLEAR, 8'hFF, 5'd31, 7'd127);
		send_request(tcw_pkg::CMD_READ, 8'h00, 5'(NUM_ROWS - 1), 7'(NUM_COLS - 1));
		send_request(tcw_pkg::CMD_READ, 8'h00, 5'd0, 7'd0);
		send_request(tcw_pkg::CMD_READ, 8'h00, 5'(NUM_ROWS), 7'd0);
		send_request(tcw_pkg::CMD_READ, 8'h00, 5'd0, 7'(NUM_COLS));
		send_request(tcw_pkg::CMD_PUT, 8'h7E, 5'd0, 7'd0);
		send_request(tcw_pkg::CMD_READ, 8'h00, 5'd1, 7'd1);
		send_request(tcw_pkg::CMD_PUT, tcw_pkg::NEWLINE_CODE, 5'd0, 7'd0);
		send_request(tcw_pkg::CMD_CLEAR, 8'h00, 5'd0, 7'd0);
		send_request(tcw_pkg::CMD_READ, 8'h00, 5'd12, 7'd40);

		run_phase(17, 65, 10, 1'b0);
		walk_to_last_row();
		fill_line(1'b1);
		run_phase(65, 17, 10, 1'b0);
		fill_line(1'b0);
		run_phase(0, 0, 15, 1'b1);

		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ran %0d requests under %0d color settings: %0d cell reads, %0d clears",
			sb.requests, color_writes + 1, sb.reads, sb.clears);
		$display("saw %0d scrolls, %0d wraps on a full line, %0d newlines on a full line",
			sb.scrolls, sb.wraps, sb.full_newlines);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("text_console_writer verification clean");
		end else begin
			$display("text_console_writer verification failed");
		end
		$finish;
	end

endmodule

@@ text_console_writer.f @@
src/tcw_pkg.sv
src/tcw_mem.sv
src/tcw_ctrl.sv
src/text_console_writer.sv
dv/text_console_writer_test.sv
